// ===== src/bfa_pkg.sv =====
// Shared types, codes and helpers of the buddy frame allocator.
package bfa_pkg;

    localparam int MAX_ORDER_DEF = 8;
    localparam int REG_W = 4;
    localparam int RIDX_REGION_ORDER = 0;

    localparam logic [2:0] FL_SPLIT  = 3'b100;
    localparam logic [2:0] FL_USED_E = 3'b010;
    localparam logic [2:0] FL_USED_O = 3'b001;

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_ALLOC_AT = 2'd1,
        OP_RELEASE  = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_ADDR_BAD  = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        C_NOP, C_LOAD, C_ASETUP, C_AIDX, C_ATSETUP, C_PRD, C_UP, C_SSRD,
        C_ATPREP, C_ATIDX, C_ULRD, C_ULWR, C_SUWR, C_SDWR, C_PT1, C_PT2,
        C_RSETUP, C_RCLR, C_SIBRD, C_MPREP, C_MWR, C_PHPREP, C_PH1, C_PH2,
        C_EMIT
    } t_cmd;

    typedef struct packed {
        t_cmd    cmd;
        t_status st;
    } t_ctl;

    typedef struct packed {
        logic big;
        logic abad;
        logic found;
        logic gt_top;
        logic idx_zero;
        logic used_self;
        logic used_sib;
        logic fl_split;
        logic lvl_zero;
        logic lvl_ge_r;
        logic out_busy;
        t_op  op;
    } t_sts;

    // Smallest o with 2^o >= c, for c of at least one.
    function automatic logic [3:0] count_order(input logic [8:0] c);
        logic [8:0] m;
        logic [3:0] o;
        m = c - 9'd1;
        o = 4'd0;
        for (int i = 0; i < 9; i++) begin
            if (m[i]) o = 4'(i + 1);
        end
        return o;
    endfunction

endpackage

// ===== src/bfa_if.sv =====
// Request and response channel interfaces of the buddy frame allocator.
interface bfa_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [8:0] frame_count;
    logic [7:0] frame_addr;
    modport source (output valid, op, frame_count, frame_addr, input ready);
    modport sink (input valid, op, frame_count, frame_addr, output ready);
endinterface

interface bfa_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] block_addr;
    modport source (output valid, status, block_addr, input ready);
    modport sink (input valid, status, block_addr, output ready);
endinterface

// ===== src/bfa_ctrl.sv =====
// Sequencer of the buddy frame allocator: walks each request through datapath commands.
module bfa_ctrl import bfa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_ctl o_ctl
);

    typedef enum logic [25:0] {
        S_IDLE  = 26'd1 << 0,
        S_DISP  = 26'd1 << 1,
        S_AFND  = 26'd1 << 2,
        S_ULRD  = 26'd1 << 3,
        S_ULWR  = 26'd1 << 4,
        S_AIDX  = 26'd1 << 5,
        S_ATIDX = 26'd1 << 6,
        S_SURD  = 26'd1 << 7,
        S_SUWR  = 26'd1 << 8,
        S_SDCHK = 26'd1 << 9,
        S_SDWR  = 26'd1 << 10,
        S_PT1   = 26'd1 << 11,
        S_PT2   = 26'd1 << 12,
        S_AWRD  = 26'd1 << 13,
        S_AWCHK = 26'd1 << 14,
        S_SSCHK = 26'd1 << 15,
        S_RWRD  = 26'd1 << 16,
        S_RWCHK = 26'd1 << 17,
        S_MRD   = 26'd1 << 18,
        S_MCHK  = 26'd1 << 19,
        S_MSCHK = 26'd1 << 20,
        S_MPRD  = 26'd1 << 21,
        S_MPWR  = 26'd1 << 22,
        S_PH1   = 26'd1 << 23,
        S_PH2   = 26'd1 << 24,
        S_FIN   = 26'd1 << 25
    } t_state;

    t_state  r_state, n_state;
    t_status r_st, n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ST_OK;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_st      = r_st;
        o_ctl.cmd = C_NOP;
        o_ctl.st  = r_st;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.cmd = C_LOAD;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.op)
                    OP_ALLOC: begin
                        if (i_sts.big) begin
                            n_st = ST_TOO_LARGE; n_state = S_FIN;
                        end else begin
                            o_ctl.cmd = C_ASETUP; n_state = S_AFND;
                        end
                    end
                    OP_ALLOC_AT: begin
                        if (i_sts.big) begin
                            n_st = ST_TOO_LARGE; n_state = S_FIN;
                        end else if (i_sts.abad) begin
                            n_st = ST_ADDR_BAD; n_state = S_FIN;
                        end else begin
                            o_ctl.cmd = C_ATSETUP; n_state = S_AWRD;
                        end
                    end
                    OP_RELEASE: begin
                        if (i_sts.abad) begin
                            n_st = ST_ADDR_BAD; n_state = S_FIN;
                        end else begin
                            o_ctl.cmd = C_RSETUP; n_state = S_RWRD;
                        end
                    end
                    default: begin
                        n_st = ST_ADDR_BAD; n_state = S_FIN;
                    end
                endcase
            end
            S_AFND: begin
                if (!i_sts.found) begin
                    n_st = ST_NO_FREE; n_state = S_FIN;
                end else begin
                    o_ctl.cmd = C_ULRD; n_state = S_ULWR;
                end
            end
            S_ULRD: begin
                o_ctl.cmd = C_ULRD; n_state = S_ULWR;
            end
            S_ULWR: begin
                o_ctl.cmd = C_ULWR;
                case (i_sts.op)
                    OP_ALLOC:    n_state = S_AIDX;
                    OP_ALLOC_AT: n_state = S_ATIDX;
                    default:     n_state = S_MPRD;
                endcase
            end
            S_AIDX: begin
                o_ctl.cmd = C_AIDX; n_state = S_SURD;
            end
            S_ATIDX: begin
                o_ctl.cmd = C_ATIDX; n_state = S_SURD;
            end
            S_SURD: begin
                o_ctl.cmd = C_PRD; n_state = S_SUWR;
            end
            S_SUWR: begin
                o_ctl.cmd = C_SUWR; n_state = S_SDCHK;
            end
            S_SDCHK: begin
                if (i_sts.gt_top) begin
                    o_ctl.cmd = C_PRD; n_state = S_SDWR;
                end else begin
                    n_st = ST_OK; n_state = S_FIN;
                end
            end
            S_SDWR: begin
                o_ctl.cmd = C_SDWR; n_state = S_PT1;
            end
            S_PT1: begin
                o_ctl.cmd = C_PT1; n_state = S_PT2;
            end
            S_PT2: begin
                o_ctl.cmd = C_PT2; n_state = S_SDCHK;
            end
            S_AWRD: begin
                if (i_sts.idx_zero) begin
                    n_st = ST_ADDR_BAD; n_state = S_FIN;
                end else begin
                    o_ctl.cmd = C_PRD; n_state = S_AWCHK;
                end
            end
            S_AWCHK: begin
                if (i_sts.used_self) begin
                    n_st = ST_ADDR_BAD; n_state = S_FIN;
                end else if (i_sts.fl_split) begin
                    if (i_sts.lvl_ge_r) begin
                        o_ctl.cmd = C_ATPREP; n_state = S_ULRD;
                    end else begin
                        o_ctl.cmd = C_SSRD; n_state = S_SSCHK;
                    end
                end else begin
                    o_ctl.cmd = C_UP; n_state = S_AWRD;
                end
            end
            S_SSCHK: begin
                if (i_sts.fl_split) begin
                    n_st = ST_ADDR_BAD; n_state = S_FIN;
                end else begin
                    o_ctl.cmd = C_ATPREP; n_state = S_ULRD;
                end
            end
            S_RWRD: begin
                o_ctl.cmd = C_PRD; n_state = S_RWCHK;
            end
            S_RWCHK: begin
                if (!i_sts.lvl_zero && !i_sts.fl_split) begin
                    o_ctl.cmd = C_UP; n_state = S_RWRD;
                end else if (!i_sts.used_self) begin
                    n_st = ST_ADDR_BAD; n_state = S_FIN;
                end else begin
                    o_ctl.cmd = C_RCLR; n_state = S_MRD;
                end
            end
            S_MRD: begin
                o_ctl.cmd = C_PRD; n_state = S_MCHK;
            end
            S_MCHK: begin
                if (i_sts.lvl_zero || i_sts.used_sib) begin
                    o_ctl.cmd = C_PHPREP; n_state = S_PH1;
                end else if (i_sts.lvl_ge_r) begin
                    o_ctl.cmd = C_MPREP; n_state = S_ULRD;
                end else begin
                    o_ctl.cmd = C_SIBRD; n_state = S_MSCHK;
                end
            end
            S_MSCHK: begin
                if (i_sts.fl_split) begin
                    o_ctl.cmd = C_PHPREP; n_state = S_PH1;
                end else begin
                    o_ctl.cmd = C_MPREP; n_state = S_ULRD;
                end
            end
            S_MPRD: begin
                o_ctl.cmd = C_PRD; n_state = S_MPWR;
            end
            S_MPWR: begin
                o_ctl.cmd = C_MWR; n_state = S_MRD;
            end
            S_PH1: begin
                o_ctl.cmd = C_PH1; n_state = S_PH2;
            end
            S_PH2: begin
                o_ctl.cmd = C_PH2; n_st = ST_OK; n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_ctl.cmd = C_EMIT; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== src/bfa_dp.sv =====
// Datapath of the buddy frame allocator: flag tree, free lists, work registers, result beat.
module bfa_dp import bfa_pkg::*; #(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctl             i_ctl,
    output t_sts             o_sts,
    input  logic [1:0]       i_op,
    input  logic [8:0]       i_frame_count,
    input  logic [7:0]       i_frame_addr,
    input  logic             i_cfg_we,
    input  logic [REG_W-1:0] i_cfg_data,
    output logic [REG_W-1:0] o_region_order,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_status,
    output logic [7:0]       o_block_addr
);

    localparam int NFR = 1 << MAX_ORDER;
    localparam int NW  = MAX_ORDER + 1;
    localparam int AW  = MAX_ORDER;
    localparam int LW  = $clog2(MAX_ORDER + 1);
    localparam logic [NW-1:0] NIL = NW'(1) << MAX_ORDER;

    logic [REG_W-1:0] r_region;
    t_op              r_op;
    logic [LW-1:0]    r_ord, r_tl, r_lvl, r_ll;
    logic             r_big, r_abad, r_found;
    logic [AW-1:0]    r_a, r_res, r_faddr;
    logic [NW-1:0]    r_idx, r_ti, r_top, r_f, r_p, r_n;

    logic [2:0]       r_fmem [NFR];
    logic [NFR-1:0]   r_fvld;
    logic [2:0]       r_fq;
    logic             r_fv;
    logic [NW-1:0]    r_nmem [NFR];
    logic [NW-1:0]    r_pmem [NFR];
    logic [NW-1:0]    r_nq, r_pq;
    logic             r_nx0, r_pv0;
    logic [NW-1:0]    r_head [MAX_ORDER+1];
    logic [NW-1:0]    r_tail [MAX_ORDER+1];

    logic             r_ovalid;
    t_status          r_ost;
    logic [7:0]       r_oaddr;

    logic [LW-1:0]    w_r, w_t, w_lv;
    logic             w_found;
    logic [8:0]       w_c1;
    logic [2:0]       w_fl, w_umask, w_smask;
    logic [NW-1:0]    w_nx, w_pv;
    logic             w_frd, w_fwe, w_nwe, w_pwe;
    logic [AW-1:0]    w_fra, w_nwa, w_pwa;
    logic [2:0]       w_fwd;
    logic [NW-1:0]    w_nwd, w_pwd;

    // Start frame of node idx at level l.
    function automatic logic [AW-1:0] start_of(input logic [NW-1:0] idx,
                                               input logic [LW-1:0] l,
                                               input logic [LW-1:0] r);
        logic [NW-1:0] v;
        v = idx & ~(NW'(1) << l);
        v = v << (r - l);
        return v[AW-1:0];
    endfunction

    assign w_r = (32'(r_region) > MAX_ORDER) ? LW'(MAX_ORDER) : LW'(r_region);
    assign w_t = w_r - r_ord;
    assign w_c1 = (i_frame_count == 9'd0) ? 9'd1 : i_frame_count;
    assign w_fl = r_fv ? r_fq : ((r_faddr == '0) ? FL_SPLIT : 3'b000);
    assign w_nx = (r_nx0 && r_f[AW-1:0] == '0) ? NIL : r_nq;
    assign w_pv = (r_pv0 && r_f[AW-1:0] == '0) ? NIL : r_pq;
    assign w_umask = r_idx[0] ? FL_USED_O : FL_USED_E;
    assign w_smask = r_idx[0] ? FL_USED_E : FL_USED_O;
    assign o_region_order = r_region;

    // Highest non-empty level at or above the target block size.
    always_comb begin
        w_found = 1'b0;
        w_lv    = '0;
        for (int l = 0; l <= MAX_ORDER; l++) begin
            if (l <= int'(w_t) && !r_head[l][MAX_ORDER]) begin
                w_found = 1'b1;
                w_lv    = LW'(l);
            end
        end
    end

    // Flag tree port selection.
    always_comb begin
        w_frd = 1'b0;
        w_fra = r_idx[AW:1];
        w_fwe = 1'b0;
        w_fwd = w_fl;
        case (i_ctl.cmd)
            C_PRD:   w_frd = 1'b1;
            C_SSRD:  begin w_frd = 1'b1; w_fra = r_idx[AW-1:0]; end
            C_SIBRD: begin w_frd = 1'b1; w_fra = r_idx[AW-1:0] ^ AW'(1); end
            C_SUWR:  begin w_fwe = 1'b1; w_fwd = w_fl | w_umask; end
            C_SDWR:  begin w_fwe = 1'b1; w_fwd = w_fl | FL_SPLIT; end
            C_RCLR:  begin w_fwe = 1'b1; w_fwd = w_fl & ~w_umask; end
            C_MWR:   begin w_fwe = 1'b1; w_fwd = w_fl & ~FL_SPLIT; end
            default: w_frd = 1'b0;
        endcase
    end

    // Free list link writes.
    always_comb begin
        w_nwe = 1'b0;
        w_nwa = r_f[AW-1:0];
        w_nwd = NIL;
        w_pwe = 1'b0;
        w_pwa = r_f[AW-1:0];
        w_pwd = NIL;
        case (i_ctl.cmd)
            C_ULWR: begin
                if (!w_pv[MAX_ORDER]) begin
                    w_nwe = 1'b1; w_nwa = w_pv[AW-1:0]; w_nwd = w_nx;
                end
                if (!w_nx[MAX_ORDER]) begin
                    w_pwe = 1'b1; w_pwa = w_nx[AW-1:0]; w_pwd = w_pv;
                end
            end
            C_PT1: begin
                w_nwe = 1'b1;
                w_pwe = 1'b1; w_pwd = r_tail[r_ll];
            end
            C_PT2: begin
                if (!r_p[MAX_ORDER]) begin
                    w_nwe = 1'b1; w_nwa = r_p[AW-1:0]; w_nwd = r_f;
                end
            end
            C_PH1: begin
                w_pwe = 1'b1;
                w_nwe = 1'b1; w_nwd = r_head[r_ll];
            end
            C_PH2: begin
                if (!r_n[MAX_ORDER]) begin
                    w_pwe = 1'b1; w_pwa = r_n[AW-1:0]; w_pwd = r_f;
                end
            end
            default: w_nwe = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_fwe) r_fmem[r_faddr] <= w_fwd;
        if (w_frd) begin
            r_fq    <= r_fmem[w_fra];
            r_fv    <= r_fvld[w_fra];
            r_faddr <= w_fra;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_nwe) r_nmem[w_nwa] <= w_nwd;
        if (w_pwe) r_pmem[w_pwa] <= w_pwd;
        if (i_ctl.cmd == C_ULRD) begin
            r_nq <= r_nmem[r_f[AW-1:0]];
            r_pq <= r_pmem[r_f[AW-1:0]];
        end
    end

    // Control state: region, flag valid bits, list ends, result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_region <= i_rst_n ? i_cfg_data : REG_W'(MAX_ORDER_DEF);
            r_fvld   <= '0;
            r_nx0    <= 1'b1;
            r_pv0    <= 1'b1;
            for (int l = 0; l <= MAX_ORDER; l++) begin
                r_head[l] <= (l == 0) ? '0 : NIL;
                r_tail[l] <= (l == 0) ? '0 : NIL;
            end
            if (!i_rst_n) r_ovalid <= 1'b0;
        end else begin
            if (w_fwe) r_fvld[r_faddr] <= 1'b1;
            if (w_nwe && w_nwa == '0) r_nx0 <= 1'b0;
            if (w_pwe && w_pwa == '0) r_pv0 <= 1'b0;
            case (i_ctl.cmd)
                C_ULWR: begin
                    if (w_pv[MAX_ORDER]) r_head[r_ll] <= w_nx;
                    if (w_nx[MAX_ORDER]) r_tail[r_ll] <= w_pv;
                end
                C_PT1: begin
                    if (r_tail[r_ll][MAX_ORDER]) r_head[r_ll] <= r_f;
                    r_tail[r_ll] <= r_f;
                end
                C_PH1: begin
                    if (r_head[r_ll][MAX_ORDER]) r_tail[r_ll] <= r_f;
                    r_head[r_ll] <= r_f;
                end
                default: begin
                end
            endcase
            if (i_ctl.cmd == C_EMIT) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    // Work registers.
    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            C_LOAD: begin
                r_op   <= t_op'(i_op);
                r_ord  <= LW'(count_order(w_c1));
                r_big  <= 32'(w_c1) > (32'd1 << w_r);
                r_abad <= 32'(i_frame_addr) >= (32'd1 << w_r);
                r_a    <= AW'(i_frame_addr);
            end
            C_ASETUP: begin
                r_tl    <= w_t;
                r_found <= w_found;
                r_ll    <= w_lv;
                r_f     <= r_head[w_lv];
            end
            C_AIDX: begin
                r_idx <= (NW'(r_f[AW-1:0]) >> r_ord) | (NW'(1) << r_tl);
                r_lvl <= r_tl;
                r_top <= (NW'(r_f[AW-1:0]) >> (w_r - r_ll)) | (NW'(1) << r_ll);
                r_res <= r_f[AW-1:0];
            end
            C_ATSETUP: begin
                r_tl  <= w_t;
                r_idx <= (NW'(r_a) >> r_ord) | (NW'(1) << w_t);
                r_ti  <= (NW'(r_a) >> r_ord) | (NW'(1) << w_t);
                r_lvl <= w_t;
            end
            C_UP, C_PT2, C_MWR: begin
                r_idx <= r_idx >> 1;
                r_lvl <= r_lvl - LW'(1);
            end
            C_ATPREP: begin
                r_ll  <= r_lvl;
                r_f   <= NW'(start_of(r_idx, r_lvl, w_r));
                r_top <= r_idx;
            end
            C_ATIDX: begin
                r_idx <= r_ti;
                r_lvl <= r_tl;
                r_res <= start_of(r_ti, r_tl, w_r);
            end
            C_SDWR, C_MPREP: begin
                r_ll <= r_lvl;
                r_f  <= NW'(start_of(r_idx ^ NW'(1), r_lvl, w_r));
            end
            C_PT1: r_p <= r_tail[r_ll];
            C_PH1: r_n <= r_head[r_ll];
            C_RSETUP: begin
                r_idx <= NW'(r_a) | (NW'(1) << w_r);
                r_lvl <= w_r;
            end
            C_RCLR: r_res <= start_of(r_idx, r_lvl, w_r);
            C_PHPREP: begin
                r_ll <= r_lvl;
                r_f  <= NW'(start_of(r_idx, r_lvl, w_r));
            end
            C_EMIT: begin
                r_ost   <= i_ctl.st;
                r_oaddr <= (i_ctl.st == ST_OK) ? 8'(r_res) : 8'd0;
            end
            default: r_op <= r_op;
        endcase
    end

    assign o_sts.big       = r_big;
    assign o_sts.abad      = r_abad;
    assign o_sts.found     = r_found;
    assign o_sts.gt_top    = r_idx > r_top;
    assign o_sts.idx_zero  = (r_idx == '0);
    assign o_sts.used_self = |(w_fl & w_umask);
    assign o_sts.used_sib  = |(w_fl & w_smask);
    assign o_sts.fl_split  = |(w_fl & FL_SPLIT);
    assign o_sts.lvl_zero  = (r_lvl == '0);
    assign o_sts.lvl_ge_r  = (r_lvl >= w_r);
    assign o_sts.out_busy  = r_ovalid && !i_ready;
    assign o_sts.op        = r_op;

    assign o_valid      = r_ovalid;
    assign o_status     = r_ost;
    assign o_block_addr = r_oaddr;

endmodule

// ===== src/buddy_frame_allocator_core.sv =====
// Top level of the buddy frame allocator: request/response channels and register port.
// Throughput: one request at a time; the next is taken once the response sits in the
// output register, so a waiting response does not stall the next request's work.
// Reset: synchronous, active low; the region order returns to 8 and the whole region
// becomes one free block at once (flag valid bits cleared, no clearing pass).
module buddy_frame_allocator_core import bfa_pkg::*; #(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfa_req_if.sink     i_req,
    bfa_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_ctl             w_ctl;
    t_sts             w_sts;
    logic             w_in_ready;
    logic             w_cfg_we;
    logic             w_reg_sel;
    logic [REG_W-1:0] w_region;

    // Register index is the word address; only the region order exists.
    assign w_reg_sel = (paddr[2] == 1'(RIDX_REGION_ORDER));
    assign w_cfg_we  = psel && penable && pwrite && w_reg_sel;
    assign pready    = 1'b1;
    assign prdata    = w_reg_sel ? 32'(w_region) : 32'd0;

    assign i_req.ready = w_in_ready;

    // Sequencer: one command per cycle into the datapath.
    bfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_ctl      (w_ctl)
    );

    // Flag tree, free lists and result beat register.
    bfa_dp #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .o_sts          (w_sts),
        .i_op           (i_req.op),
        .i_frame_count  (i_req.frame_count),
        .i_frame_addr   (i_req.frame_addr),
        .i_cfg_we       (w_cfg_we),
        .i_cfg_data     (pwdata[REG_W-1:0]),
        .o_region_order (w_region),
        .o_valid        (o_rsp.valid),
        .i_ready        (o_rsp.ready),
        .o_status       (o_rsp.status),
        .o_block_addr   (o_rsp.block_addr)
    );

endmodule

// ===== sim/tb_buddy_frame_allocator_core.sv =====
// Self-checking testbench of the buddy frame allocator: predicted responses versus DUT.
module tb_buddy_frame_allocator_core import bfa_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NFR = 256;
    localparam int NIL = 256;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        t_status    status;
        logic [7:0] block_addr;
    } t_rsp;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bfa_req_if req_ch ();
    bfa_rsp_if rsp_ch ();

    buddy_frame_allocator_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: a shadow of the allocator's tree and free lists.
    logic [2:0] shadow_flags [NFR];
    int         shadow_next  [NFR];
    int         shadow_prev  [NFR];
    int         shadow_head  [9];
    int         shadow_tail  [9];
    logic [3:0] shadow_order;

    t_rsp pending_rsp [$];
    int   fail_count;
    int   cycle_count;
    int   rsp_seen;
    int   rsp_wait;
    // Frames currently held, used to aim releases at live blocks.
    int   held_frames [$];

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int eff_order();
        return (shadow_order > 4'd8) ? 8 : int'(shadow_order);
    endfunction

    function automatic void clear_shadow();
        for (int i = 0; i < NFR; i++) begin
            shadow_flags[i] = 3'b000;
            shadow_next[i]  = 0;
            shadow_prev[i]  = 0;
        end
        for (int l = 0; l < 9; l++) begin
            shadow_head[l] = NIL;
            shadow_tail[l] = NIL;
        end
        shadow_flags[0] = FL_SPLIT;
        shadow_head[0] = 0;
        shadow_tail[0] = 0;
        shadow_next[0] = NIL;
        shadow_prev[0] = NIL;
    endfunction

    function automatic int node_level(int idx);
        int l;
        l = 0;
        while (idx > 1) begin
            idx = idx >> 1;
            l++;
        end
        return l;
    endfunction

    function automatic int node_start(int idx, int l, int r);
        return (idx - (1 << l)) << (r - l);
    endfunction

    function automatic logic [2:0] used_mask(int idx);
        return (idx & 1) ? FL_USED_O : FL_USED_E;
    endfunction

    function automatic bit node_used(int idx);
        return |(shadow_flags[(idx >> 1) & 255] & used_mask(idx));
    endfunction

    function automatic bit split_above(int idx);
        return |(shadow_flags[(idx >> 1) & 255] & FL_SPLIT);
    endfunction

    function automatic bit split_here(int idx, int r);
        if (node_level(idx) >= r) return 1'b0;
        return |(shadow_flags[idx & 255] & FL_SPLIT);
    endfunction

    function automatic void unlink_free(int l, int f);
        int p, n;
        f = f & 255;
        p = shadow_prev[f];
        n = shadow_next[f];
        if (p >= NIL) shadow_head[l] = n; else shadow_next[p & 255] = n;
        if (n >= NIL) shadow_tail[l] = p; else shadow_prev[n & 255] = p;
    endfunction

    function automatic void append_free(int l, int f);
        int t;
        t = shadow_tail[l];
        f = f & 255;
        shadow_next[f] = NIL;
        shadow_prev[f] = t;
        if (t >= NIL) shadow_head[l] = f; else shadow_next[t & 255] = f;
        shadow_tail[l] = f;
    endfunction

    function automatic void prepend_free(int l, int f);
        int h;
        h = shadow_head[l];
        f = f & 255;
        shadow_prev[f] = NIL;
        shadow_next[f] = h;
        if (h >= NIL) shadow_tail[l] = f; else shadow_prev[h & 255] = f;
        shadow_head[l] = f;
    endfunction

    // Split from the found block down to the target, parking each buddy at its list tail.
    function automatic void carve_down(int top, int idx, int r);
        int l;
        while (idx > top) begin
            l = node_level(idx);
            shadow_flags[(idx >> 1) & 255] |= FL_SPLIT;
            append_free(l, node_start(idx ^ 1, l, r));
            idx = idx >> 1;
        end
    endfunction

    // Work out the response of one request and update the shadow tree.
    function automatic t_rsp predict_allocation(t_op op, logic [8:0] cnt, logic [7:0] addr);
        t_rsp rsp;
        int r, c, a, o, t, idx, b, lv, f, ti, found, l;
        r = eff_order();
        c = (cnt == 0) ? 1 : int'(cnt);
        a = int'(addr);
        o = 0;
        rsp.status = ST_ADDR_BAD;
        rsp.block_addr = 8'd0;
        if (op == OP_ALLOC || op == OP_ALLOC_AT) begin
            if (c > (1 << r)) begin
                rsp.status = ST_TOO_LARGE;
                return rsp;
            end
            while ((1 << o) < c) o++;
            t = r - o;
            if (op == OP_ALLOC) begin
                // Nearest non-empty level at or above the target.
                lv = t + 1;
                found = 0;
                while (lv > 0 && found == 0) begin
                    lv--;
                    if (shadow_head[lv] < NIL) found = 1;
                end
                if (found == 0) begin
                    rsp.status = ST_NO_FREE;
                    return rsp;
                end
                f = shadow_head[lv] & 255;
                unlink_free(lv, f);
                idx = (f >> o) + (1 << t);
                shadow_flags[(idx >> 1) & 255] |= used_mask(idx);
                carve_down((f >> (r - lv)) + (1 << lv), idx, r);
                rsp.status = ST_OK;
                rsp.block_addr = 8'(f);
            end else begin
                if (a >= (1 << r)) return rsp;
                ti = (a >> o) + (1 << t);
                idx = ti;
                found = 0;
                while (idx > 0) begin
                    if (node_used(idx)) break;
                    if (split_above(idx)) begin
                        found = idx;
                        break;
                    end
                    idx = idx >> 1;
                end
                if (found == 0 || split_here(found, r)) return rsp;
                l = node_level(found);
                unlink_free(l, node_start(found, l, r));
                shadow_flags[(ti >> 1) & 255] |= used_mask(ti);
                carve_down(found, ti, r);
                rsp.status = ST_OK;
                rsp.block_addr = 8'(node_start(ti, t, r));
            end
        end else if (op == OP_RELEASE) begin
            if (a >= (1 << r)) return rsp;
            idx = a + (1 << r);
            b = r;
            while (b > 0 && !split_above(idx)) begin
                idx = idx >> 1;
                b--;
            end
            if (!node_used(idx)) return rsp;
            rsp.block_addr = 8'(node_start(idx, b, r));
            shadow_flags[(idx >> 1) & 255] &= ~used_mask(idx);
            // Merge upward while the buddy is free and whole.
            while (b > 0 && !node_used(idx ^ 1) && !split_here(idx ^ 1, r)) begin
                unlink_free(b, node_start(idx ^ 1, b, r));
                shadow_flags[(idx >> 1) & 255] &= ~FL_SPLIT;
                idx = idx >> 1;
                b--;
            end
            prepend_free(b, node_start(idx, b, r));
            rsp.status = ST_OK;
        end
        return rsp;
    endfunction

    // Send one request beat after a random gap; predict at acceptance.
    // Valid stays high after the accept; the next gap or drain() drops it.
    task automatic send_request(t_op op, logic [8:0] cnt, logic [7:0] addr);
        t_rsp rsp;
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.frame_count <= cnt;
        req_ch.frame_addr  <= addr;
        do @(posedge i_clk); while (!req_ch.ready);
        rsp = predict_allocation(op, cnt, addr);
        pending_rsp.push_back(rsp);
        if (rsp.status == ST_OK) begin
            if (op == OP_RELEASE) begin
                for (int i = 0; i < held_frames.size(); i++) begin
                    if (held_frames[i] == int'(rsp.block_addr)) begin
                        held_frames.delete(i);
                        break;
                    end
                end
            end else begin
                held_frames.push_back(int'(rsp.block_addr));
            end
        end
    endtask

    // Draw a random receiver stall for each response.
    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_wait     <= 0;
        end else if (rsp_ch.valid && rsp_ch.ready) begin
            w = $urandom_range(0, 4);
            rsp_ch.ready <= (w == 0);
            rsp_wait     <= w;
        end else if (!rsp_ch.ready) begin
            if (rsp_wait <= 1) begin
                rsp_ch.ready <= 1'b1;
                rsp_wait     <= 0;
            end else begin
                rsp_wait <= rsp_wait - 1;
            end
        end
    end

    // Compare each response beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen <= rsp_seen + 1;
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected beat status=%0d block_addr=%0d", $time,
                         rsp_ch.status, rsp_ch.block_addr);
                fail_count++;
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.block_addr !== want.block_addr) begin
                    $display("%0t: block_addr expected %0d actual %0d", $time,
                             want.block_addr, rsp_ch.block_addr);
                    fail_count++;
                end
            end
        end
    end

    // Drop valid, wait until every predicted response has arrived, then let the core settle.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // Write the region order through the register port; the store reinitializes.
    task automatic write_region_order(logic [3:0] order);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(RIDX_REGION_ORDER * 4);
        pwdata  <= 32'(order);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_order = order;
        clear_shadow();
        held_frames.delete();
    endtask

    function automatic logic [8:0] random_count();
        case ($urandom_range(0, 9))
            0: return 9'($urandom_range(0, 511));
            1, 2: return 9'($urandom_range(0, 256));
            default: return 9'(1 << $urandom_range(0, eff_order())) - 9'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic logic [7:0] random_addr();
        if (held_frames.size() != 0 && $urandom_range(0, 3) != 0)
            return 8'(held_frames[$urandom_range(0, held_frames.size() - 1)]
                      + $urandom_range(0, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_extremes();
        send_request(OP_ALLOC, 9'd256, 8'd0);
        send_request(OP_ALLOC, 9'd1, 8'd0);
        send_request(OP_RELEASE, 9'd0, 8'd0);
        send_request(OP_ALLOC, 9'd257, 8'd0);
        send_request(OP_ALLOC, 9'd511, 8'd0);
        send_request(OP_ALLOC, 9'd0, 8'd0);
        send_request(OP_ALLOC, 9'd3, 8'd0);
        send_request(OP_ALLOC_AT, 9'd4, 8'd255);
        send_request(OP_ALLOC_AT, 9'd4, 8'd254);
        send_request(OP_ALLOC_AT, 9'd1, 8'd0);
        send_request(OP_ALLOC_AT, 9'd8, 8'd2);
        send_request(OP_RELEASE, 9'd0, 8'd253);
        send_request(OP_RELEASE, 9'd0, 8'd253);
        send_request(OP_RELEASE, 9'd511, 8'd1);
        send_request(OP_NONE, 9'd511, 8'd255);
        send_request(OP_ALLOC_AT, 9'd256, 8'd128);
    endtask

    task automatic test_small_region();
        write_region_order(4'd0);
        send_request(OP_ALLOC, 9'd2, 8'd0);
        send_request(OP_ALLOC, 9'd1, 8'd0);
        send_request(OP_ALLOC, 9'd1, 8'd0);
        send_request(OP_ALLOC_AT, 9'd1, 8'd1);
        send_request(OP_RELEASE, 9'd0, 8'd1);
        send_request(OP_RELEASE, 9'd0, 8'd0);
        write_region_order(4'd15);
        send_request(OP_ALLOC_AT, 9'd16, 8'd40);
        send_request(OP_RELEASE, 9'd0, 8'd47);
    endtask

    // Mostly allocations paired with releases of held blocks, some noise.
    task automatic test_random_traffic(int items);
        int pick;
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 8)
                send_request(OP_ALLOC, random_count(), random_addr());
            else if (pick < 12)
                send_request(OP_ALLOC_AT, random_count(), random_addr());
            else if (pick < 19)
                send_request(OP_RELEASE, 9'($urandom_range(0, 511)), random_addr());
            else
                send_request(t_op'($urandom_range(0, 3)), 9'($urandom_range(0, 511)),
                             8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.op          = OP_ALLOC;
        req_ch.frame_count = 9'd0;
        req_ch.frame_addr  = 8'd0;
        rsp_ch.ready       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = 3'd0;
        pwdata             = 32'd0;
        fail_count         = 0;
        cycle_count        = 0;
        rsp_seen           = 0;
        shadow_order       = 4'd8;
        clear_shadow();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_small_region();
        write_region_order(4'd8);
        test_random_traffic(400);
        // Hold the sender until every response is back.
        drain();
        write_region_order(4'd3);
        test_random_traffic(250);
        write_region_order(4'd5);
        test_random_traffic(250);
        write_region_order(4'd1);
        test_random_traffic(100);
        write_region_order(4'd8);
        test_random_traffic(300);
        drain();

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
src/bfa_pkg.sv
src/bfa_if.sv
src/bfa_ctrl.sv
src/bfa_dp.sv
src/buddy_frame_allocator_core.sv
sim/tb_buddy_frame_allocator_core.sv
